/* hdl/rcrt_pkg.sv */
`default_nettype none

package rcrt_pkg;

  // number of tracked channels; the frame always carries eight pulse ports
  localparam int NumChannels = 8;
  localparam int MaxPorts    = 8;

  localparam int PulseW = 16;
  localparam int IdxW   = 3;
  localparam int CountW = 8;
  localparam int RssiW  = 9;
  localparam int TotalW = 32;
  localparam int SpanW  = 16;
  localparam int SavedW = 4;
  localparam int CfgIdxW = 2;

  localparam logic [PulseW-1:0] PulseAbsentHi = 16'hFFFF;
  localparam logic [RssiW-1:0]  RssiNone      = 9'h1FF;
  localparam logic [SpanW-1:0]  MinSpanReset  = 16'd200;
  localparam logic [SavedW-1:0] SavedReset    = 4'd6;

  // command codes
  localparam logic [1:0] CmdSample  = 2'd0;
  localparam logic [1:0] CmdCapture = 2'd1;
  localparam logic [1:0] CmdClear   = 2'd2;
  localparam logic [1:0] CmdRead    = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMinSpan       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSavedChannels = 2'd1;

  typedef struct packed {
    logic [PulseW-1:0] value;
    logic [PulseW-1:0] minimum;
    logic [PulseW-1:0] maximum;
    logic [PulseW-1:0] trim;
    logic              seen;
  } chan_t;

  typedef struct packed {
    logic            save_ready;
    logic [IdxW-1:0] first_bad;
  } save_status_t;

endpackage

`default_nettype wire

/* hdl/rcrt_lane.sv */
`default_nettype none

module rcrt_lane
  import rcrt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [PulseW-1:0] pulse_i,
  input  wire logic              present_i,
  output chan_t                  chan_d_o,
  output logic                   updated_o,
  output logic                   captured_o
);

  chan_t chan_q;
  chan_t chan_d;
  logic  pulse_ok;

  assign pulse_ok = present_i && (pulse_i != '0) && (pulse_i != PulseAbsentHi);

  always_comb begin
    chan_d     = chan_q;
    updated_o  = 1'b0;
    captured_o = 1'b0;
    case (cmd_i)
      CmdSample: begin
        if (pulse_ok) begin
          chan_d.value = pulse_i;
          if (!chan_q.seen || pulse_i < chan_q.minimum) chan_d.minimum = pulse_i;
          if (!chan_q.seen || pulse_i > chan_q.maximum) chan_d.maximum = pulse_i;
          if (chan_q.trim == '0) chan_d.trim = pulse_i;
          chan_d.seen = 1'b1;
          updated_o   = 1'b1;
        end
      end
      CmdCapture: begin
        if (chan_q.seen && chan_q.value != '0) begin
          chan_d.trim = chan_q.value;
          captured_o  = 1'b1;
        end
      end
      CmdClear: begin
        chan_d = '0;
      end
      default: begin
        chan_d = chan_q;
      end
    endcase
  end

  assign chan_d_o = chan_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
    end else if (fire_i) begin
      chan_q <= chan_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/rcrt_save_check.sv */
`default_nettype none

module rcrt_save_check
  import rcrt_pkg::*;
(
  input  wire chan_t [NumChannels-1:0] chan_i,
  input  wire logic [SpanW-1:0]        min_span_i,
  input  wire logic [SavedW-1:0]       saved_channels_i,
  output save_status_t                 status_o
);

  logic [SavedW-1:0]      checked;
  logic [NumChannels-1:0] fail;

  assign checked = (saved_channels_i > SavedW'(NumChannels)) ? SavedW'(NumChannels)
                                                            : saved_channels_i;

  always_comb begin
    for (int i = 0; i < NumChannels; i++) begin
      fail[i] = (SavedW'(i) < checked) &&
                (!chan_i[i].seen ||
                 (chan_i[i].maximum < chan_i[i].minimum) ||
                 ((chan_i[i].maximum - chan_i[i].minimum) < min_span_i));
    end
  end

  // lowest failing channel wins
  always_comb begin
    status_o.save_ready = 1'b1;
    status_o.first_bad  = '0;
    for (int i = NumChannels - 1; i >= 0; i--) begin
      if (fail[i]) begin
        status_o.save_ready = 1'b0;
        status_o.first_bad  = IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/rc_channel_range_tracker.sv */
`default_nettype none

// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    cmd, pulse_ch1..8, frame_count, frame_rssi,
//                                                 read_index
// out       output     out_valid_o / out_ready_i  frame_changed .. first_bad_channel
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one beat per cycle while the output is not stalled; an accepted beat passes through the input
// register, then the channel update and save check feed the result register
// the channel stores are committed in the same edge that loads the result register
// reset clears all channel stores, the sample counter, rssi to -1, config to defaults
// a stalled output holds the input register; in_ready_o falls only when both are full
// cfg_ready_o is always high; writes are expected only while the block is idle

module rc_channel_range_tracker
  import rcrt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input beat
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [PulseW-1:0]  pulse_ch1_i,
  input  wire logic [PulseW-1:0]  pulse_ch2_i,
  input  wire logic [PulseW-1:0]  pulse_ch3_i,
  input  wire logic [PulseW-1:0]  pulse_ch4_i,
  input  wire logic [PulseW-1:0]  pulse_ch5_i,
  input  wire logic [PulseW-1:0]  pulse_ch6_i,
  input  wire logic [PulseW-1:0]  pulse_ch7_i,
  input  wire logic [PulseW-1:0]  pulse_ch8_i,
  input  wire logic [CountW-1:0]  frame_count_i,
  input  wire logic [7:0]         frame_rssi_i,
  input  wire logic [IdxW-1:0]    read_index_i,
  // result beat
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    frame_changed_o,
  output logic                    trim_captured_o,
  output logic [TotalW-1:0]       samples_seen_o,
  output logic signed [RssiW-1:0] last_rssi_o,
  output logic [PulseW-1:0]       sel_value_o,
  output logic [PulseW-1:0]       sel_minimum_o,
  output logic [PulseW-1:0]       sel_maximum_o,
  output logic [PulseW-1:0]       sel_trim_o,
  output logic                    sel_seen_o,
  output logic [PulseW-1:0]       sel_save_trim_o,
  output logic                    save_ready_o,
  output logic [IdxW-1:0]         first_bad_channel_o,
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [SpanW-1:0]   cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SpanW-1:0]  min_span_q;
  logic [SavedW-1:0] saved_channels_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_span_q       <= MinSpanReset;
      saved_channels_q <= SavedReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMinSpan:       min_span_q       <= cfg_data_i;
        CfgSavedChannels: saved_channels_q <= cfg_data_i[SavedW-1:0];
        default:          ; // unknown index is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic                                in_valid_q;
  logic [1:0]                          cmd_q;
  logic [MaxPorts-1:0][PulseW-1:0]     pulse_q;
  logic [CountW-1:0]                   count_q;
  logic [7:0]                          rssi_q;
  logic [IdxW-1:0]                     sel_q;
  logic [MaxPorts-1:0][PulseW-1:0]     pulse_in;
  logic                                fire;  // input register moves into result register

  assign pulse_in = {pulse_ch8_i, pulse_ch7_i, pulse_ch6_i, pulse_ch5_i,
                     pulse_ch4_i, pulse_ch3_i, pulse_ch2_i, pulse_ch1_i};

  assign fire       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q   <= cmd_i;
      pulse_q <= pulse_in;
      count_q <= frame_count_i;
      rssi_q  <= frame_rssi_i;
      sel_q   <= read_index_i;
    end
  end

  // ---------------------------------------------------------------------------
  // channel lanes, all updated side by side
  // ---------------------------------------------------------------------------
  chan_t [NumChannels-1:0] chan_d;
  logic  [NumChannels-1:0] lane_updated;
  logic  [NumChannels-1:0] lane_captured;

  for (genvar g = 0; g < NumChannels; g++) begin : g_lane
    rcrt_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .fire_i     (fire),
      .cmd_i      (cmd_q),
      .pulse_i    (pulse_q[g]),
      .present_i  (count_q > CountW'(g)),  // frame count clamps at the lane count
      .chan_d_o   (chan_d[g]),
      .updated_o  (lane_updated[g]),
      .captured_o (lane_captured[g])
    );
  end

  // ---------------------------------------------------------------------------
  // shared counters
  // ---------------------------------------------------------------------------
  logic [TotalW-1:0] sample_total_q, sample_total_d;
  logic [RssiW-1:0]  stored_rssi_q, stored_rssi_d;
  logic              changed, captured;

  assign changed  = (cmd_q == CmdSample) && (|lane_updated);
  assign captured = (cmd_q == CmdCapture) && (|lane_captured);

  always_comb begin
    sample_total_d = sample_total_q;
    stored_rssi_d  = stored_rssi_q;
    if (cmd_q == CmdClear) begin
      sample_total_d = '0;
      stored_rssi_d  = RssiNone;
    end else if (changed) begin
      // saturate at all ones
      if (sample_total_q != '1) sample_total_d = sample_total_q + TotalW'(1);
      stored_rssi_d = {1'b0, rssi_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_total_q <= '0;
      stored_rssi_q  <= RssiNone;
    end else if (fire) begin
      sample_total_q <= sample_total_d;
      stored_rssi_q  <= stored_rssi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // selected channel and save check, on the post-command state
  // ---------------------------------------------------------------------------
  chan_t             sel_chan;
  logic              sel_ok;
  logic [PulseW:0]   mid_sum;
  logic [PulseW-1:0] save_trim;
  save_status_t      status;

  assign sel_ok   = (int'(sel_q) < NumChannels);
  assign sel_chan = sel_ok ? chan_d[sel_q] : '0;
  assign mid_sum  = {1'b0, sel_chan.minimum} + {1'b0, sel_chan.maximum};
  // trim unset: fall back to the range midpoint
  assign save_trim = (sel_chan.trim != '0) ? sel_chan.trim : mid_sum[PulseW:1];

  rcrt_save_check u_save_check (
    .chan_i           (chan_d),
    .min_span_i       (min_span_q),
    .saved_channels_i (saved_channels_q),
    .status_o         (status)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      frame_changed_o     <= changed;
      trim_captured_o     <= captured;
      samples_seen_o      <= sample_total_d;
      last_rssi_o         <= stored_rssi_d;
      sel_value_o         <= sel_chan.value;
      sel_minimum_o       <= sel_chan.minimum;
      sel_maximum_o       <= sel_chan.maximum;
      sel_trim_o          <= sel_chan.trim;
      sel_seen_o          <= sel_chan.seen;
      sel_save_trim_o     <= save_trim;
      save_ready_o        <= status.save_ready;
      first_bad_channel_o <= status.first_bad;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (cmd_q != CmdClear) |=> sample_total_q >= $past(sample_total_q))
    else $error("sample counter went backwards without a clear");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_changed_o && trim_captured_o))
    else $error("frame and capture flags both set");

  a_ready_no_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && save_ready_o |-> first_bad_channel_o == '0)
    else $error("bad channel reported while save ready");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

/* test/tb_rc_channel_range_tracker.sv */
`default_nettype none

module tb_rc_channel_range_tracker;
  import rcrt_pkg::*;

  // cycles to let the pipeline settle once nothing is pending
  localparam int SettleCycles = 6;
  // hard stop, far beyond the slowest legal run
  localparam int TimeLimit = 2_000_000;

  // one input beat as the sender sees it; pulse[0] is channel 1
  typedef struct packed {
    logic [1:0]                      cmd;
    logic [MaxPorts-1:0][PulseW-1:0] pulse;
    logic [CountW-1:0]               count;
    logic [7:0]                      rssi;
    logic [IdxW-1:0]                 sel;
  } frame_beat_t;

  // one result beat, field for field
  typedef struct packed {
    logic              changed;
    logic              captured;
    logic [TotalW-1:0] total;
    logic [RssiW-1:0]  rssi;
    logic [PulseW-1:0] value;
    logic [PulseW-1:0] minimum;
    logic [PulseW-1:0] maximum;
    logic [PulseW-1:0] trim;
    logic              seen;
    logic [PulseW-1:0] save;
    logic              ready;
    logic [IdxW-1:0]   bad;
  } tracker_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic [PulseW-1:0]  pulse_ch1_i, pulse_ch2_i, pulse_ch3_i, pulse_ch4_i;
  logic [PulseW-1:0]  pulse_ch5_i, pulse_ch6_i, pulse_ch7_i, pulse_ch8_i;
  logic [CountW-1:0]  frame_count_i;
  logic [7:0]         frame_rssi_i;
  logic [IdxW-1:0]    read_index_i;

  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    frame_changed_o;
  logic                    trim_captured_o;
  logic [TotalW-1:0]       samples_seen_o;
  logic signed [RssiW-1:0] last_rssi_o;
  logic [PulseW-1:0]       sel_value_o, sel_minimum_o, sel_maximum_o, sel_trim_o;
  logic                    sel_seen_o;
  logic [PulseW-1:0]       sel_save_trim_o;
  logic                    save_ready_o;
  logic [IdxW-1:0]         first_bad_channel_o;

  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [SpanW-1:0]   cfg_data_i;

  // shadow copy of the channel stores and registers
  logic [PulseW-1:0] ch_value [NumChannels];
  logic [PulseW-1:0] ch_min   [NumChannels];
  logic [PulseW-1:0] ch_max   [NumChannels];
  logic [PulseW-1:0] ch_trim  [NumChannels];
  logic              ch_seen  [NumChannels];
  logic [TotalW-1:0] sample_count;
  logic [RssiW-1:0]  rssi_hold;
  logic [SpanW-1:0]  span_limit;
  logic [SavedW-1:0] checked_count;

  // results still owed by the block, oldest first
  tracker_result_t pending_reports [$];

  // when set, neither side inserts gaps or stalls
  bit quiet_mode = 1'b0;

  int n_errors   = 0;
  int n_beats    = 0;
  int n_results  = 0;
  int n_updates  = 0;
  int n_captures = 0;
  int n_clears   = 0;
  int n_ready    = 0;
  int n_writes   = 0;

  rc_channel_range_tracker uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .pulse_ch1_i        (pulse_ch1_i),
    .pulse_ch2_i        (pulse_ch2_i),
    .pulse_ch3_i        (pulse_ch3_i),
    .pulse_ch4_i        (pulse_ch4_i),
    .pulse_ch5_i        (pulse_ch5_i),
    .pulse_ch6_i        (pulse_ch6_i),
    .pulse_ch7_i        (pulse_ch7_i),
    .pulse_ch8_i        (pulse_ch8_i),
    .frame_count_i      (frame_count_i),
    .frame_rssi_i       (frame_rssi_i),
    .read_index_i       (read_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .frame_changed_o    (frame_changed_o),
    .trim_captured_o    (trim_captured_o),
    .samples_seen_o     (samples_seen_o),
    .last_rssi_o        (last_rssi_o),
    .sel_value_o        (sel_value_o),
    .sel_minimum_o      (sel_minimum_o),
    .sel_maximum_o      (sel_maximum_o),
    .sel_trim_o         (sel_trim_o),
    .sel_seen_o         (sel_seen_o),
    .sel_save_trim_o    (sel_save_trim_o),
    .save_ready_o       (save_ready_o),
    .first_bad_channel_o(first_bad_channel_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // 4 time unit period
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // wipe every channel store; rssi goes back to "none"
  function automatic void clear_tracker();
    for (int i = 0; i < NumChannels; i++) begin
      ch_value[i] = '0;
      ch_min[i]   = '0;
      ch_max[i]   = '0;
      ch_trim[i]  = '0;
      ch_seen[i]  = 1'b0;
    end
    sample_count = '0;
    rssi_hold    = RssiNone;
  endfunction

  // apply one accepted beat to the shadow state and return the result it owes
  function automatic tracker_result_t update_tracker(frame_beat_t b);
    tracker_result_t   r;
    int                lanes;
    int                limit;
    logic [PulseW-1:0] p;
    logic [PulseW:0]   mid;
    r = '0;
    if (b.cmd == CmdSample) begin
      // frame count clamps to the channel count
      lanes = (b.count > NumChannels) ? NumChannels : int'(b.count);
      for (int i = 0; i < lanes; i++) begin
        p = b.pulse[i];
        // 0 and all-ones mean the channel is absent
        if (p != '0 && p != PulseAbsentHi) begin
          if (!ch_seen[i] || p < ch_min[i]) ch_min[i] = p;
          if (!ch_seen[i] || p > ch_max[i]) ch_max[i] = p;
          if (ch_trim[i] == '0) ch_trim[i] = p;
          ch_value[i] = p;
          ch_seen[i]  = 1'b1;
          r.changed   = 1'b1;
        end
      end
      // an empty frame leaves counter and rssi alone
      if (r.changed) begin
        if (sample_count != '1) sample_count = sample_count + TotalW'(1);
        rssi_hold = {1'b0, b.rssi};
        n_updates++;
      end
    end else if (b.cmd == CmdCapture) begin
      for (int i = 0; i < NumChannels; i++) begin
        if (ch_seen[i] && ch_value[i] != '0) begin
          ch_trim[i] = ch_value[i];
          r.captured = 1'b1;
        end
      end
      if (r.captured) n_captures++;
    end else if (b.cmd == CmdClear) begin
      clear_tracker();
      n_clears++;
    end

    // save check over the leading channels; zero checked means ready
    limit = (checked_count > NumChannels) ? NumChannels : int'(checked_count);
    r.ready = 1'b1;
    for (int i = 0; i < limit; i++) begin
      if (r.ready && (!ch_seen[i] || ch_max[i] < ch_min[i] ||
                      (ch_max[i] - ch_min[i]) < span_limit)) begin
        r.ready = 1'b0;
        r.bad   = IdxW'(i);
      end
    end
    if (r.ready) n_ready++;

    r.total = sample_count;
    r.rssi  = rssi_hold;
    if (b.sel < NumChannels) begin
      mid       = ({1'b0, ch_min[b.sel]} + {1'b0, ch_max[b.sel]}) >> 1;
      r.value   = ch_value[b.sel];
      r.minimum = ch_min[b.sel];
      r.maximum = ch_max[b.sel];
      r.trim    = ch_trim[b.sel];
      r.seen    = ch_seen[b.sel];
      // stored trim wins, else midpoint of the seen range
      r.save    = (ch_trim[b.sel] != '0) ? ch_trim[b.sel] : mid[PulseW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // gap or stall length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // beat with the same pulse on every channel
  function automatic frame_beat_t flat_beat(logic [1:0] cmd, logic [PulseW-1:0] p,
                                            logic [CountW-1:0] count, logic [7:0] rssi,
                                            logic [IdxW-1:0] sel);
    frame_beat_t b;
    b.cmd   = cmd;
    b.count = count;
    b.rssi  = rssi;
    b.sel   = sel;
    for (int i = 0; i < MaxPorts; i++) b.pulse[i] = p;
    return b;
  endfunction

  // pulse mix: mostly a plausible stick range, with absent and edge values
  function automatic logic [PulseW-1:0] random_pulse();
    int r;
    r = $urandom_range(0, 99);
    if (r < 7)  return '0;
    if (r < 14) return PulseAbsentHi;
    if (r < 19) return PulseW'($urandom_range(0, 65535));
    if (r < 22) return 16'd1;
    if (r < 24) return 16'd65534;
    return PulseW'($urandom_range(800, 2200));
  endfunction

  function automatic frame_beat_t random_beat();
    frame_beat_t b;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 78)      b.cmd = CmdSample;
    else if (r < 88) b.cmd = CmdRead;
    else if (r < 96) b.cmd = CmdCapture;
    else             b.cmd = CmdClear;
    r = $urandom_range(0, 99);
    if (r < 80)      b.count = CountW'(NumChannels);
    else if (r < 90) b.count = CountW'($urandom_range(0, NumChannels));
    else             b.count = CountW'($urandom_range(0, 255));
    for (int i = 0; i < MaxPorts; i++) b.pulse[i] = random_pulse();
    b.rssi = 8'($urandom_range(0, 255));
    b.sel  = IdxW'($urandom_range(0, NumChannels - 1));
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------------

  // push one beat through the input handshake, then book its expected result
  task automatic send_beat(input frame_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    cmd_i         <= b.cmd;
    pulse_ch1_i   <= b.pulse[0];
    pulse_ch2_i   <= b.pulse[1];
    pulse_ch3_i   <= b.pulse[2];
    pulse_ch4_i   <= b.pulse[3];
    pulse_ch5_i   <= b.pulse[4];
    pulse_ch6_i   <= b.pulse[5];
    pulse_ch7_i   <= b.pulse[6];
    pulse_ch8_i   <= b.pulse[7];
    frame_count_i <= b.count;
    frame_rssi_i  <= b.rssi;
    read_index_i  <= b.sel;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_reports.push_back(update_tracker(b));
    n_beats++;
  endtask

  // stop sending and let every owed result come back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SpanW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    // only the low bits of the checked count are kept
    if (idx == CfgMinSpan) span_limit = data;
    else if (idx == CfgSavedChannels) checked_count = data[SavedW-1:0];
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // registers change only with the block drained
  task automatic set_config(input logic [SpanW-1:0] span, input logic [SpanW-1:0] saved);
    wait_idle();
    write_reg(CfgMinSpan, span);
    write_reg(CfgSavedChannels, saved);
  endtask

  // random traffic, switching in and out of gap-free stretches
  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      send_beat(random_beat());
    end
    quiet_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // stores straight out of reset: zeros, rssi -1, not ready with default check
  task automatic test_reset_state();
    send_beat(flat_beat(CmdRead, 16'd1234, 8'd8, 8'd77, 3'd0));
    send_beat(flat_beat(CmdRead, '0, '0, '0, 3'd7));
  endtask

  // pulse extremes, absent pulses, empty frames and count clamping
  task automatic test_frame_edges();
    frame_beat_t b;
    send_beat(flat_beat(CmdSample, 16'd1, 8'd8, 8'd0, 3'd0));
    send_beat(flat_beat(CmdSample, 16'd65534, 8'd8, 8'd255, 3'd1));
    // every pulse absent, counter and rssi must hold
    send_beat(flat_beat(CmdSample, '0, 8'd8, 8'd10, 3'd2));
    send_beat(flat_beat(CmdSample, PulseAbsentHi, 8'd8, 8'd11, 3'd3));
    // zero count with good pulses is still empty
    send_beat(flat_beat(CmdSample, 16'd1500, 8'd0, 8'd12, 3'd4));
    // count far past eight clamps
    send_beat(flat_beat(CmdSample, 16'd1500, 8'd255, 8'd13, 3'd7));
    // partial count and a mix of absent and present
    b = flat_beat(CmdSample, 16'd2000, 8'd3, 8'd128, 3'd2);
    b.pulse[0] = '0;
    b.pulse[1] = 16'd32768;
    b.pulse[3] = 16'd900;
    send_beat(b);
    b = flat_beat(CmdSample, 16'd32767, 8'd9, 8'd1, 3'd5);
    b.pulse[4] = PulseAbsentHi;
    send_beat(b);
  endtask

  // trim capture on seen channels, clear, then capture with nothing seen
  task automatic test_capture_and_clear();
    send_beat(flat_beat(CmdCapture, 16'hA5A5, 8'd8, 8'd99, 3'd2));
    send_beat(flat_beat(CmdRead, '0, '0, '0, 3'd6));
    send_beat(flat_beat(CmdClear, 16'd1700, 8'd8, 8'd50, 3'd0));
    send_beat(flat_beat(CmdCapture, 16'd1700, 8'd8, 8'd50, 3'd3));
    // single channel seen: midpoint path and trim from first sight
    send_beat(flat_beat(CmdSample, 16'd1100, 8'd1, 8'd200, 3'd0));
    send_beat(flat_beat(CmdSample, 16'd1900, 8'd1, 8'd201, 3'd0));
    send_beat(flat_beat(CmdRead, '0, '0, '0, 3'd1));
  endtask

  // register extremes: nothing checked, over-range count, widest and zero span
  task automatic test_register_extremes();
    set_config(16'd0, 16'd0);
    run_random(25);
    set_config(16'd65535, 16'd15);
    run_random(25);
    set_config(16'd0, 16'd8);
    run_random(25);
    set_config(16'd1, 16'd1);
    run_random(25);
  endtask

  // longer random phases under assorted settings, junk in the unused data bits
  task automatic test_random_traffic();
    logic [SpanW-1:0] span;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 4))
        0: span = 16'd100;
        1: span = MinSpanReset;
        2: span = 16'd400;
        3: span = 16'd1000;
        default: span = SpanW'($urandom_range(0, 65535));
      endcase
      set_config(span, {12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15))});
      run_random(125);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 n_results, name, exp_v, act_v);
    end
  endtask

  // compare every accepted result beat with the oldest owed result
  always @(posedge clk_i) begin : result_check
    tracker_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("result beat with nothing owed");
      end else begin
        exp_r = pending_reports.pop_front();
        check_field("frame_changed", 32'(exp_r.changed), 32'(frame_changed_o));
        check_field("trim_captured", 32'(exp_r.captured), 32'(trim_captured_o));
        check_field("samples_seen", exp_r.total, samples_seen_o);
        check_field("last_rssi", 32'(exp_r.rssi), 32'($unsigned(last_rssi_o)));
        check_field("sel_value", 32'(exp_r.value), 32'(sel_value_o));
        check_field("sel_minimum", 32'(exp_r.minimum), 32'(sel_minimum_o));
        check_field("sel_maximum", 32'(exp_r.maximum), 32'(sel_maximum_o));
        check_field("sel_trim", 32'(exp_r.trim), 32'(sel_trim_o));
        check_field("sel_seen", 32'(exp_r.seen), 32'(sel_seen_o));
        check_field("sel_save_trim", 32'(exp_r.save), 32'(sel_save_trim_o));
        check_field("save_ready", 32'(exp_r.ready), 32'(save_ready_o));
        check_field("first_bad_channel", 32'(exp_r.bad), 32'(first_bad_channel_o));
        n_results++;
      end
    end
  end

  // receiver: ready runs broken by random stalls, none in quiet stretches
  initial begin : out_stall_gen
    int stall;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // watchdog
  initial begin
    #TimeLimit;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    // known values on every input before the first edge
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CmdRead;
    pulse_ch1_i   = '0;
    pulse_ch2_i   = '0;
    pulse_ch3_i   = '0;
    pulse_ch4_i   = '0;
    pulse_ch5_i   = '0;
    pulse_ch6_i   = '0;
    pulse_ch7_i   = '0;
    pulse_ch8_i   = '0;
    frame_count_i = '0;
    frame_rssi_i  = '0;
    read_index_i  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgMinSpan;
    cfg_data_i    = '0;
    clear_tracker();
    span_limit    = MinSpanReset;
    checked_count = SavedReset;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_frame_edges();
    test_capture_and_clear();
    test_register_extremes();
    test_random_traffic();
    wait_idle();

    if (pending_reports.size() != 0) begin
      n_errors++;
      $display("%0d results never arrived", pending_reports.size());
    end
    $display("ran %0d beats: %0d updating frames, %0d trim captures, %0d clears",
             n_beats, n_updates, n_captures, n_clears);
    $display("checked %0d results (%0d save-ready) across %0d register writes",
             n_results, n_ready, n_writes);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/rcrt_pkg.sv
hdl/rcrt_lane.sv
hdl/rcrt_save_check.sv
hdl/rc_channel_range_tracker.sv
test/tb_rc_channel_range_tracker.sv
